FILE: rtl/spt_pkg.sv
`timescale 1ns / 1ps

package spt_pkg;

	// fixed port widths
	localparam int OP_W      = 2;
	localparam int IN_FACE_W = 16;
	localparam int TGT_W     = 10;
	localparam int RES_IDX_W = 10;
	localparam int RES_TOT_W = 11;
	localparam int FAULT_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_MERGE  = 2'd0,
		OP_FINISH = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_ORDER = 2'd1,
		FAULT_FULL  = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MRG_CMP,
		ST_LK_CMP,
		ST_RES
	} state_t;

	// one result word
	typedef struct packed {
		logic                 found;
		logic [RES_IDX_W-1:0] index;
		logic                 mark;
		logic [RES_TOT_W-1:0] total;
		fault_t               fault;
	} res_t;

endpackage

FILE: rtl/spt_ram.sv
`timescale 1ns / 1ps

module spt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/spt_out_stage.sv
`timescale 1ns / 1ps

module spt_out_stage
	import spt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  res_t res,
	output logic res_ready,
	output logic result_valid,
	input  logic result_stall,
	output res_t word
);

	logic valid_q;
	res_t word_q;

	// slot is free when empty or being drained this cycle
	assign res_ready    = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign word         = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			word_q <= res;
		end
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> result_valid)
		else $error("result word not presented after load");

endmodule

FILE: rtl/spt_engine.sv
`timescale 1ns / 1ps

module spt_engine
	import spt_pkg::*;
#(
	parameter int MAX_PAIRS = 1024,
	parameter int FACE_BITS = 16,
	localparam int KEY_W  = 2 * FACE_BITS,
	localparam int IDX_W  = $clog2(MAX_PAIRS),
	localparam int ADDR_W = IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item side
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [OP_W-1:0]       op,
	input  logic [IN_FACE_W-1:0]  first_face,
	input  logic [IN_FACE_W-1:0]  second_face,
	input  logic [TGT_W-1:0]      target_index,
	input  logic                  mark_value,
	// key memory
	output logic                  key_we,
	output logic [ADDR_W-1:0]     key_waddr,
	output logic [KEY_W-1:0]      key_wdata,
	input  logic [KEY_W-1:0]      key_rdata,
	// mark memory
	output logic                  mark_we,
	output logic [ADDR_W-1:0]     mark_waddr,
	output logic                  mark_wdata,
	input  logic                  mark_rdata,
	// shared read port address
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr,
	// result side
	output logic                  res_valid,
	output res_t                  res,
	input  logic                  res_ready
);

	localparam int CNT_W = $clog2(MAX_PAIRS + 1);
	localparam int CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] old_pos_q, old_pos_d;
	logic [CNT_W-1:0] nwp_q, nwp_d;
	logic             bank_q, bank_d;
	logic             open_q, open_d;
	logic [KEY_W-1:0] prev_q, prev_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [IDX_W-1:0] mid_q, mid_d;
	res_t             res_q, res_d;

	logic [KEY_W-1:0] item_key;
	logic [CNT_W-1:0] total_cur;
	logic [CNT_W-1:0] pos_inc;
	logic [CNT_W-1:0] nwp_inc;
	logic             entry_ok, ent_lt, ent_eq, mk;
	logic [CNT_W-1:0] lo_n, hi_n;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] mid_n;

	assign item_key  = {FACE_BITS'(first_face), FACE_BITS'(second_face)};
	assign total_cur = open_q ? nwp_q : count_q;
	assign pos_inc   = old_pos_q + CNT_W'(1);
	assign nwp_inc   = nwp_q + CNT_W'(1);

	// merge scan compare against the old entry just read
	assign entry_ok = old_pos_q < count_q;
	assign ent_lt   = entry_ok && (key_rdata < key_q);
	assign ent_eq   = entry_ok && (key_rdata == key_q);
	assign mk       = ent_eq && mark_rdata;

	// binary search bounds for the next probe
	always_comb begin
		if (state_q == ST_LK_CMP) begin
			if (key_rdata < key_q) begin
				lo_n = CNT_W'(mid_q) + CNT_W'(1);
				hi_n = hi_q;
			end else begin
				lo_n = lo_q;
				hi_n = CNT_W'(mid_q);
			end
		end else begin
			lo_n = '0;
			hi_n = count_q;
		end
	end

	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = mid_sum[IDX_W:1];

	assign item_stall = (state_q != ST_IDLE);
	assign res_valid  = (state_q == ST_RES);
	assign res        = res_q;

	// next state and memory control
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		old_pos_d  = old_pos_q;
		nwp_d      = nwp_q;
		bank_d     = bank_q;
		open_d     = open_q;
		prev_d     = prev_q;
		key_d      = key_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		res_d      = res_q;
		key_we     = 1'b0;
		key_waddr  = {~bank_q, nwp_q[IDX_W-1:0]};
		key_wdata  = key_q;
		mark_we    = 1'b0;
		mark_waddr = {~bank_q, nwp_q[IDX_W-1:0]};
		mark_wdata = mk;
		rd_en      = 1'b0;
		rd_addr    = '0;

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					key_d = item_key;
					case (op_t'(op))
						OP_MERGE: begin
							if (open_q && (item_key <= prev_q)) begin
								res_d = '{found: 1'b0, index: '0, mark: 1'b0,
									total: RES_TOT_W'(nwp_q), fault: FAULT_ORDER};
								state_d = ST_RES;
							end else if (open_q && (nwp_q >= MAX_CNT)) begin
								res_d = '{found: 1'b0, index: '0, mark: 1'b0,
									total: RES_TOT_W'(nwp_q), fault: FAULT_FULL};
								state_d = ST_RES;
							end else begin
								// first pair opens the pass
								open_d = 1'b1;
								if (!open_q) begin
									old_pos_d = '0;
									nwp_d     = '0;
								end
								rd_en   = 1'b1;
								rd_addr = {bank_q, open_q ? old_pos_q[IDX_W-1:0] : IDX_W'(0)};
								state_d = ST_MRG_CMP;
							end
						end
						OP_FINISH: begin
							if (open_q) begin
								count_d = nwp_q;
								bank_d  = ~bank_q;
								open_d  = 1'b0;
							end else begin
								count_d = '0;
							end
							old_pos_d = '0;
							nwp_d     = '0;
							res_d = '{found: 1'b0, index: '0, mark: 1'b0,
								total: open_q ? RES_TOT_W'(nwp_q) : RES_TOT_W'(0),
								fault: FAULT_NONE};
							state_d = ST_RES;
						end
						OP_LOOKUP: begin
							if (count_q == '0) begin
								res_d = '{found: 1'b0, index: '0, mark: 1'b0,
									total: RES_TOT_W'(total_cur), fault: FAULT_NONE};
								state_d = ST_RES;
							end else begin
								lo_d    = lo_n;
								hi_d    = hi_n;
								mid_d   = mid_n;
								rd_en   = 1'b1;
								rd_addr = {bank_q, mid_n};
								state_d = ST_LK_CMP;
							end
						end
						OP_SET: begin
							if (CMP_W'(target_index) < CMP_W'(count_q)) begin
								mark_we    = 1'b1;
								mark_waddr = {bank_q, IDX_W'(target_index)};
								mark_wdata = mark_value;
								res_d = '{found: 1'b1, index: RES_IDX_W'(target_index),
									mark: mark_value, total: RES_TOT_W'(total_cur),
									fault: FAULT_NONE};
							end else begin
								res_d = '{found: 1'b0, index: '0, mark: 1'b0,
									total: RES_TOT_W'(total_cur), fault: FAULT_NONE};
							end
							state_d = ST_RES;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			ST_MRG_CMP: begin
				if (ent_lt && (pos_inc < count_q)) begin
					// drop the old entry, fetch the next one
					old_pos_d = pos_inc;
					rd_en     = 1'b1;
					rd_addr   = {bank_q, pos_inc[IDX_W-1:0]};
				end else begin
					if (ent_lt || ent_eq) begin
						old_pos_d = pos_inc;
					end
					key_we  = 1'b1;
					mark_we = 1'b1;
					prev_d  = key_q;
					nwp_d   = nwp_inc;
					res_d = '{found: ent_eq, index: RES_IDX_W'(nwp_q), mark: mk,
						total: RES_TOT_W'(nwp_inc), fault: FAULT_NONE};
					state_d = ST_RES;
				end
			end

			ST_LK_CMP: begin
				if (key_rdata == key_q) begin
					res_d = '{found: 1'b1, index: RES_IDX_W'(mid_q), mark: mark_rdata,
						total: RES_TOT_W'(total_cur), fault: FAULT_NONE};
					state_d = ST_RES;
				end else if (lo_n < hi_n) begin
					lo_d    = lo_n;
					hi_d    = hi_n;
					mid_d   = mid_n;
					rd_en   = 1'b1;
					rd_addr = {bank_q, mid_n};
				end else begin
					res_d = '{found: 1'b0, index: '0, mark: 1'b0,
						total: RES_TOT_W'(total_cur), fault: FAULT_NONE};
					state_d = ST_RES;
				end
			end

			ST_RES: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			old_pos_q <= '0;
			nwp_q     <= '0;
			bank_q    <= 1'b0;
			open_q    <= 1'b0;
			prev_q    <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			old_pos_q <= old_pos_d;
			nwp_q     <= nwp_d;
			bank_q    <= bank_d;
			open_q    <= open_d;
			prev_q    <= prev_d;
		end
	end

	// item payload and search registers
	always_ff @(posedge clk) begin
		key_q <= key_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		res_q <= res_d;
	end

	a_pos_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		old_pos_q <= count_q)
		else $error("old read position past committed entries");

	a_new_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		nwp_q <= MAX_CNT)
		else $error("new list longer than table");

	a_spare_bank: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (key_waddr[IDX_W] == !bank_q))
		else $error("merge write into committed bank");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LK_CMP |-> (lo_q < hi_q) && (CNT_W'(mid_q) < hi_q))
		else $error("lookup probe outside search window");

endmodule

FILE: rtl/sorted_pair_table_merge_core.sv
`timescale 1ns / 1ps

// Sorted face-pair table with streaming merge. Pairs live in two banks of a
// key memory and a mark memory; a merge pass writes the spare bank and a
// finish word commits it. Every word takes one result word. A merge pair
// walks the old bank one entry per cycle through the single read port,
// dropping old entries that sort below it; a lookup is a binary search on
// that port with at most ceil(log2(entries + 1)) probes. A new word is taken
// once the previous result has moved to the output register. Tables hold up
// to MAX_PAIRS pairs of FACE_BITS-bit faces; wider input faces are truncated.
module sorted_pair_table_merge_core
	import spt_pkg::*;
#(
	parameter int MAX_PAIRS = 1024,
	parameter int FACE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [IN_FACE_W-1:0] first_face,
	input  logic [IN_FACE_W-1:0] second_face,
	input  logic [TGT_W-1:0]     target_index,
	input  logic                 mark_value,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 found,
	output logic [RES_IDX_W-1:0] result_index,
	output logic                 mark_out,
	output logic [RES_TOT_W-1:0] entry_total,
	output logic [FAULT_W-1:0]   fault
);

	localparam int KEY_W     = 2 * FACE_BITS;
	localparam int IDX_W     = $clog2(MAX_PAIRS);
	localparam int ADDR_W    = IDX_W + 1;
	localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

	logic              key_we, mark_we, rd_en;
	logic [ADDR_W-1:0] key_waddr, mark_waddr, rd_addr;
	logic [KEY_W-1:0]  key_wdata, key_rdata;
	logic              mark_wdata, mark_rdata;
	logic              res_valid, res_ready;
	res_t              res, word;

	// pair keys, both banks
	spt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (RAM_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	// active marks, same addressing
	spt_ram #(
		.WIDTH (1),
		.DEPTH (RAM_DEPTH)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (mark_rdata)
	);

	spt_engine #(
		.MAX_PAIRS (MAX_PAIRS),
		.FACE_BITS (FACE_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.first_face   (first_face),
		.second_face  (second_face),
		.target_index (target_index),
		.mark_value   (mark_value),
		.key_we       (key_we),
		.key_waddr    (key_waddr),
		.key_wdata    (key_wdata),
		.key_rdata    (key_rdata),
		.mark_we      (mark_we),
		.mark_waddr   (mark_waddr),
		.mark_wdata   (mark_wdata),
		.mark_rdata   (mark_rdata),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready)
	);

	spt_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.word         (word)
	);

	assign found        = word.found;
	assign result_index = word.index;
	assign mark_out     = word.mark;
	assign entry_total  = word.total;
	assign fault        = word.fault;

endmodule
